// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the point location RTL.
// Assertions compile away when SYNTH is defined; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SLPH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SLPH_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define SLPH_ASSERT(label, prop, msg)
`define SLPH_ASSERT_NEVER(label, expr, msg)
`endif
`endif

// ===== hw/rtl/slph_pkg.sv =====
// Types, constants and codes shared by the point location histogram block.
// No dependencies.
package slph_pkg;

  localparam int unsigned MAX_SEGMENTS  = 1024;
  localparam int unsigned COORD_BITS    = 24;
  localparam int unsigned COUNT_BITS    = 32;
  localparam int unsigned INDEX_BITS    = 11;
  localparam int unsigned FUNC_BITS     = 2;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = COORD_BITS;
  localparam int unsigned SEG_ADDR_BITS = $clog2(MAX_SEGMENTS);
  localparam int unsigned CNT_DEPTH     = MAX_SEGMENTS + 1;
  localparam int unsigned PROD_BITS     = 2 * (COORD_BITS + 1);

  localparam logic KIND_PLACE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_PLACE = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TOP_Y     = 2'd0,
    REG_BOTTOM_Y  = 2'd1,
    REG_SEG_COUNT = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic seg_load;
    logic place_init;
    logic read_issue;
    logic clear_step;
    logic probe_issue;
    logic probe_mul;
    logic probe_update;
    logic count_issue;
    logic count_write;
    logic read_out;
  } cmd_t;

  typedef struct packed {
    logic search_open;
    logic clear_last;
  } status_t;

endpackage

// ===== hw/rtl/slph_ctrl.sv =====
// Sequencer for the point location histogram block.
// Depends on slph_pkg for the command and status structs and the function codes.
module slph_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  input  logic [slph_pkg::FUNC_BITS-1:0]      func_i,
  input  slph_pkg::status_t                   status_i,
  output slph_pkg::cmd_t                      cmd_o,
  output logic                                busy
);
  import slph_pkg::*;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_SEARCH = 7'b0000100,
    ST_MUL    = 7'b0001000,
    ST_CMP    = 7'b0010000,
    ST_INC    = 7'b0100000,
    ST_RDOUT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          unique case (func_e'(func_i))
            FUNC_LOAD: begin
              cmd_o.seg_load = 1'b1;
            end
            FUNC_PLACE: begin
              cmd_o.place_init = 1'b1;
              state_d          = ST_SEARCH;
            end
            FUNC_READ: begin
              cmd_o.read_issue = 1'b1;
              state_d          = ST_RDOUT;
            end
            FUNC_CLEAR: begin
              state_d = ST_CLEAR;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_SEARCH: begin
        if (status_i.search_open) begin
          cmd_o.probe_issue = 1'b1;
          state_d           = ST_MUL;
        end else begin
          cmd_o.count_issue = 1'b1;
          state_d           = ST_INC;
        end
      end
      ST_MUL: begin
        cmd_o.probe_mul = 1'b1;
        state_d         = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.probe_update = 1'b1;
        state_d            = ST_SEARCH;
      end
      ST_INC: begin
        cmd_o.count_write = 1'b1;
        state_d           = ST_IDLE;
      end
      ST_RDOUT: begin
        cmd_o.read_out = 1'b1;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

// ===== hw/rtl/slph_datapath.sv =====
// Segment table, counter memory, cross product unit and search registers.
// Depends on slph_pkg and assert_macros.svh.
module slph_datapath (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  slph_pkg::cmd_t                          cmd_i,
  output slph_pkg::status_t                       status_o,
  input  logic [slph_pkg::INDEX_BITS-1:0]         slot_i,
  input  logic signed [slph_pkg::COORD_BITS-1:0]  upper_x_i,
  input  logic signed [slph_pkg::COORD_BITS-1:0]  lower_x_i,
  input  logic signed [slph_pkg::COORD_BITS-1:0]  point_x_i,
  input  logic signed [slph_pkg::COORD_BITS-1:0]  point_y_i,
  input  logic                                    cfg_we_i,
  input  logic [slph_pkg::CFG_IDX_BITS-1:0]       cfg_idx_i,
  input  logic [slph_pkg::CFG_DATA_BITS-1:0]      cfg_data_i,
  output logic                                    strobe_o,
  output logic                                    kind_o,
  output logic [slph_pkg::INDEX_BITS-1:0]         compartment_o,
  output logic [slph_pkg::COUNT_BITS-1:0]         tally_o
);
  import slph_pkg::*;

  `include "assert_macros.svh"

  localparam logic [INDEX_BITS-1:0] MaxIdx = INDEX_BITS'(MAX_SEGMENTS);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COORD_BITS:0]   diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;

  coord_t                  top_y_q, bottom_y_q;
  logic [INDEX_BITS-1:0]   seg_count_q;

  logic [2*COORD_BITS-1:0] seg_mem [MAX_SEGMENTS];
  logic [2*COORD_BITS-1:0] seg_rd_q;
  logic [COUNT_BITS-1:0]   cnt_mem [CNT_DEPTH];
  logic [COUNT_BITS-1:0]   cnt_rd_q;

  coord_t                  px_q;
  diff_t                   dy_q, dt_q;
  prod_t                   p1_q, p2_q;
  logic [INDEX_BITS-1:0]   lo_q, hp_q, mid_q, slot_q, clr_q;
  logic                    read_ok_q;

  logic                    strobe_q, kind_q;
  logic [INDEX_BITS-1:0]   comp_q;
  logic [COUNT_BITS-1:0]   tally_q;

  logic [INDEX_BITS:0]     mid_sum;
  logic [INDEX_BITS-1:0]   mid_d, seg_count_lim;
  coord_t                  seg_u, seg_l;
  diff_t                   du, dx;
  logic [COUNT_BITS-1:0]   cnt_inc;
  logic                    cnt_we, cnt_re;
  logic [INDEX_BITS-1:0]   cnt_waddr, cnt_raddr;
  logic [COUNT_BITS-1:0]   cnt_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_y_q     <= '0;
      bottom_y_q  <= '0;
      seg_count_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_TOP_Y:     top_y_q     <= cfg_data_i[COORD_BITS-1:0];
        REG_BOTTOM_Y:  bottom_y_q  <= cfg_data_i[COORD_BITS-1:0];
        REG_SEG_COUNT: seg_count_q <= cfg_data_i[INDEX_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.seg_load && (slot_i < MaxIdx)) begin
      seg_mem[slot_i[SEG_ADDR_BITS-1:0]] <= {upper_x_i, lower_x_i};
    end
    if (cmd_i.probe_issue) begin
      seg_rd_q <= seg_mem[mid_d[SEG_ADDR_BITS-1:0]];
    end
  end

  assign mid_sum       = {1'b0, lo_q} + {1'b0, hp_q} - {{INDEX_BITS{1'b0}}, 1'b1};
  assign mid_d         = mid_sum[INDEX_BITS:1];
  assign seg_count_lim = (seg_count_q > MaxIdx) ? MaxIdx : seg_count_q;

  assign seg_u = seg_rd_q[2*COORD_BITS-1:COORD_BITS];
  assign seg_l = seg_rd_q[COORD_BITS-1:0];
  assign du    = $signed({seg_u[COORD_BITS-1], seg_u}) - $signed({seg_l[COORD_BITS-1], seg_l});
  assign dx    = $signed({px_q[COORD_BITS-1], px_q}) - $signed({seg_l[COORD_BITS-1], seg_l});

  always_ff @(posedge clk_i) begin
    if (cmd_i.place_init) begin
      px_q <= point_x_i;
      dy_q <= $signed({point_y_i[COORD_BITS-1], point_y_i})
            - $signed({bottom_y_q[COORD_BITS-1], bottom_y_q});
      dt_q <= $signed({top_y_q[COORD_BITS-1], top_y_q})
            - $signed({bottom_y_q[COORD_BITS-1], bottom_y_q});
    end
    if (cmd_i.probe_mul) begin
      p1_q <= du * dy_q;
      p2_q <= dt_q * dx;
    end
    if (cmd_i.probe_issue) begin
      mid_q <= mid_d;
    end
    if (cmd_i.read_issue) begin
      slot_q    <= slot_i;
      read_ok_q <= (slot_i <= MaxIdx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q <= '0;
      hp_q <= '0;
    end else if (cmd_i.place_init) begin
      lo_q <= '0;
      hp_q <= seg_count_lim;
    end else if (cmd_i.probe_update) begin
      if (p1_q >= p2_q) begin
        hp_q <= mid_q;
      end else begin
        lo_q <= mid_q + INDEX_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_step) begin
      clr_q <= (clr_q == MaxIdx) ? '0 : clr_q + INDEX_BITS'(1);
    end
  end

  assign cnt_inc   = (cnt_rd_q == '1) ? cnt_rd_q : cnt_rd_q + COUNT_BITS'(1);
  assign cnt_we    = cmd_i.clear_step || cmd_i.count_write;
  assign cnt_waddr = cmd_i.clear_step ? clr_q : lo_q;
  assign cnt_wdata = cmd_i.clear_step ? '0 : cnt_inc;
  assign cnt_re    = cmd_i.count_issue || cmd_i.read_issue;
  assign cnt_raddr = cmd_i.count_issue ? lo_q : ((slot_i <= MaxIdx) ? slot_i : '0);

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_rd_q <= cnt_mem[cnt_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.count_write || cmd_i.read_out;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.count_write) begin
      kind_q  <= KIND_PLACE;
      comp_q  <= lo_q;
      tally_q <= cnt_inc;
    end else if (cmd_i.read_out) begin
      kind_q  <= KIND_READ;
      comp_q  <= slot_q;
      tally_q <= read_ok_q ? cnt_rd_q : '0;
    end
  end

  assign status_o.search_open = (lo_q < hp_q);
  assign status_o.clear_last  = (clr_q == MaxIdx);

  assign strobe_o      = strobe_q;
  assign kind_o        = kind_q;
  assign compartment_o = comp_q;
  assign tally_o       = tally_q;

  `SLPH_ASSERT(a_lo_le_hp, lo_q <= hp_q, "Search bounds crossed.")
  `SLPH_ASSERT(a_hp_bound, hp_q <= MaxIdx, "Search bound above the segment table.")
  `SLPH_ASSERT_NEVER(a_one_writer, cmd_i.clear_step && cmd_i.count_write, "Two counter writes.")
  `SLPH_ASSERT(a_strobe_src, strobe_q |-> $past(cmd_i.count_write || cmd_i.read_out), "Stray word.")
  `SLPH_ASSERT(a_place_nonzero, (strobe_q && kind_q == KIND_PLACE) |-> tally_q != '0, "Zero tally.")

endmodule

// ===== hw/rtl/slab_point_location_histogram.sv =====
// Top level of the point location histogram block.
// Depends on slph_pkg, slph_ctrl and slph_datapath.
//
// A place command binary-searches the loaded segments with an exact cross product test,
// bumps the saturating counter of the compartment it lands in and returns one word.
// Each probe steps through segment read, multiply and compare, and a place makes at most
// ceil(log2(n+1)) probes for n active segments. Its word appears in the first cycle with
// busy low again. A read keeps busy high for one cycle and shows its word in the first
// cycle with busy low again, a load completes at the accepting edge, and a clear sweeps
// the counter memory one entry a cycle over all 1025 entries. The same sweep runs after
// reset before the first command is taken; configuration writes are taken at any time.
// Each result word is shown for exactly one cycle with strobe_o high and cannot be held
// off, so the receiver must take it then.
module slab_point_location_histogram (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start,
  output logic                                    busy,
  input  logic [slph_pkg::FUNC_BITS-1:0]          func_i,
  input  logic [slph_pkg::INDEX_BITS-1:0]         slot_i,
  input  logic signed [slph_pkg::COORD_BITS-1:0]  upper_x_i,
  input  logic signed [slph_pkg::COORD_BITS-1:0]  lower_x_i,
  input  logic signed [slph_pkg::COORD_BITS-1:0]  point_x_i,
  input  logic signed [slph_pkg::COORD_BITS-1:0]  point_y_i,
  input  logic                                    cfg_we_i,
  input  logic [slph_pkg::CFG_IDX_BITS-1:0]       cfg_idx_i,
  input  logic [slph_pkg::CFG_DATA_BITS-1:0]      cfg_data_i,
  output logic                                    strobe_o,
  output logic                                    kind_o,
  output logic [slph_pkg::INDEX_BITS-1:0]         compartment_o,
  output logic [slph_pkg::COUNT_BITS-1:0]         tally_o
);
  import slph_pkg::*;

  cmd_t    cmd;
  status_t status;

  slph_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .func_i   (func_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  slph_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .slot_i        (slot_i),
    .upper_x_i     (upper_x_i),
    .lower_x_i     (lower_x_i),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .strobe_o      (strobe_o),
    .kind_o        (kind_o),
    .compartment_o (compartment_o),
    .tally_o       (tally_o)
  );

endmodule

// ===== sim/slph_scoreboard.sv =====
`timescale 1ns / 100ps
// Scoreboard for the point location histogram block: watches the command, register and
// result ports, predicts each result word and compares it field by field.
// Depends on slph_pkg.
module slph_scoreboard (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic                                   busy_i,
  input  logic [slph_pkg::FUNC_BITS-1:0]         func_i,
  input  logic [slph_pkg::INDEX_BITS-1:0]        slot_i,
  input  logic signed [slph_pkg::COORD_BITS-1:0] upper_x_i,
  input  logic signed [slph_pkg::COORD_BITS-1:0] lower_x_i,
  input  logic signed [slph_pkg::COORD_BITS-1:0] point_x_i,
  input  logic signed [slph_pkg::COORD_BITS-1:0] point_y_i,
  input  logic                                   cfg_we_i,
  input  logic [slph_pkg::CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  logic [slph_pkg::CFG_DATA_BITS-1:0]     cfg_data_i,
  input  logic                                   strobe_i,
  input  logic                                   kind_i,
  input  logic [slph_pkg::INDEX_BITS-1:0]        compartment_i,
  input  logic [slph_pkg::COUNT_BITS-1:0]        tally_i,
  output int                                     fail_count_o,
  output int                                     due_count_o
);
  import slph_pkg::*;

  typedef struct packed {
    logic                  kind;
    logic [INDEX_BITS-1:0] compartment;
    logic [COUNT_BITS-1:0] tally;
  } tally_word_t;

  logic signed [COORD_BITS-1:0] seg_upper [MAX_SEGMENTS];
  logic signed [COORD_BITS-1:0] seg_lower [MAX_SEGMENTS];
  logic [COUNT_BITS-1:0]        counts [CNT_DEPTH];
  logic signed [COORD_BITS-1:0] top_y;
  logic signed [COORD_BITS-1:0] bottom_y;
  logic [INDEX_BITS-1:0]        seg_count;
  tally_word_t                  due_words [$];
  tally_word_t                  want;
  int                           hit;
  int                           mismatches;

  // Products of two 25-bit differences fit easily in 64 bits, so the test is exact.
  function automatic bit on_or_left(longint px, longint py, int s);
    longint u, l, lhs, rhs;
    u = seg_upper[s];
    l = seg_lower[s];
    lhs = (u - l) * (py - longint'(bottom_y));
    rhs = (longint'(top_y) - longint'(bottom_y)) * (px - l);
    return lhs >= rhs;
  endfunction

  function automatic int locate_compartment(longint px, longint py);
    int n, lo, hi, mid;
    n = seg_count;
    if (n > int'(MAX_SEGMENTS)) n = MAX_SEGMENTS;
    lo = 0;
    hi = n - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (on_or_left(px, py, mid)) hi = mid - 1;
      else lo = mid + 1;
    end
    return lo;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (counts[i]) counts[i] = '0;
      top_y = '0;
      bottom_y = '0;
      seg_count = '0;
      due_words.delete();
      mismatches = 0;
      fail_count_o <= 0;
      due_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TOP_Y:     top_y = cfg_data_i[COORD_BITS-1:0];
          REG_BOTTOM_Y:  bottom_y = cfg_data_i[COORD_BITS-1:0];
          REG_SEG_COUNT: seg_count = cfg_data_i[INDEX_BITS-1:0];
          default: ;
        endcase
      end
      if (strobe_i) begin
        if (due_words.size() == 0) begin
          $display("%0t: result word with none due, actual kind %0d compartment %0d tally %0d",
                   $time, kind_i, compartment_i, tally_i);
          mismatches++;
        end else begin
          want = due_words.pop_front();
          if (kind_i !== want.kind) begin
            $display("%0t: kind mismatch, expected %0d, actual %0d", $time, want.kind, kind_i);
            mismatches++;
          end
          if (compartment_i !== want.compartment) begin
            $display("%0t: compartment mismatch, expected %0d, actual %0d",
                     $time, want.compartment, compartment_i);
            mismatches++;
          end
          if (tally_i !== want.tally) begin
            $display("%0t: tally mismatch, expected %0d, actual %0d",
                     $time, want.tally, tally_i);
            mismatches++;
          end
        end
      end
      if (start_i && !busy_i) begin
        case (func_i)
          FUNC_LOAD: begin
            if (slot_i < MAX_SEGMENTS) begin
              seg_upper[slot_i] = upper_x_i;
              seg_lower[slot_i] = lower_x_i;
            end
          end
          FUNC_CLEAR: foreach (counts[i]) counts[i] = '0;
          FUNC_READ: begin
            want.kind = KIND_READ;
            want.compartment = slot_i;
            want.tally = (slot_i <= MAX_SEGMENTS) ? counts[slot_i] : '0;
            due_words.push_back(want);
          end
          default: begin
            hit = locate_compartment(point_x_i, point_y_i);
            if (counts[hit] != '1) counts[hit] = counts[hit] + 1'b1;
            want.kind = KIND_PLACE;
            want.compartment = hit[INDEX_BITS-1:0];
            want.tally = counts[hit];
            due_words.push_back(want);
          end
        endcase
      end
      fail_count_o <= mismatches;
      due_count_o <= due_words.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for slab_point_location_histogram: drives commands in random bursts and
// register writes between phases, and reports the verdict. Depends on slph_pkg, the DUT and slph_scoreboard.
module tb;
  import slph_pkg::*;

  localparam int COORD_MIN    = -(1 << (COORD_BITS - 1));
  localparam int COORD_MAX    = (1 << (COORD_BITS - 1)) - 1;
  localparam int COORD_SPAN   = 1 << COORD_BITS;
  localparam int SLOT_TOP     = (1 << INDEX_BITS) - 1;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 16;
  localparam int RUN_LIMIT    = 1000000;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  func_e                        func;
  logic [INDEX_BITS-1:0]        slot;
  logic signed [COORD_BITS-1:0] upper_x;
  logic signed [COORD_BITS-1:0] lower_x;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         cfg_we;
  cfg_reg_e                     cfg_idx;
  logic [CFG_DATA_BITS-1:0]     cfg_data;
  logic                         strobe;
  logic                         kind;
  logic [INDEX_BITS-1:0]        compartment;
  logic [COUNT_BITS-1:0]        tally;
  int                           fail_count;
  int                           due_count;

  int          burst_left;
  int          cur_top;
  int          cur_bottom;
  int          cur_count;
  int          lay_upper [MAX_SEGMENTS];
  int          lay_lower [MAX_SEGMENTS];
  int          ph, pick, done, nsel, ty, by, swap;
  int unsigned cycles = 0;

  always #5 clk = ~clk;

  slab_point_location_histogram i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start         (start),
    .busy          (busy),
    .func_i        (func),
    .slot_i        (slot),
    .upper_x_i     (upper_x),
    .lower_x_i     (lower_x),
    .point_x_i     (point_x),
    .point_y_i     (point_y),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .strobe_o      (strobe),
    .kind_o        (kind),
    .compartment_o (compartment),
    .tally_o       (tally)
  );

  slph_scoreboard i_scoreboard (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start_i       (start),
    .busy_i        (busy),
    .func_i        (func),
    .slot_i        (slot),
    .upper_x_i     (upper_x),
    .lower_x_i     (lower_x),
    .point_x_i     (point_x),
    .point_y_i     (point_y),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .strobe_i      (strobe),
    .kind_i        (kind),
    .compartment_i (compartment),
    .tally_i       (tally),
    .fail_count_o  (fail_count),
    .due_count_o   (due_count)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("slab_point_location_histogram verification failed");
      $finish;
    end
  end

  // Returns at the edge that accepts the word.
  task automatic put_cmd(func_e f, int s, int ux, int lx, int px, int py);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    start <= 1'b1;
    func <= f;
    slot <= INDEX_BITS'(s);
    upper_x <= COORD_BITS'(ux);
    lower_x <= COORD_BITS'(lx);
    point_x <= COORD_BITS'(px);
    point_y <= COORD_BITS'(py);
    do @(posedge clk); while (busy);
  endtask

  task automatic settle();
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_regs(int top, int bottom, int n);
    cfg_we <= 1'b1;
    cfg_idx <= REG_TOP_Y;
    cfg_data <= CFG_DATA_BITS'(top);
    @(posedge clk);
    cfg_idx <= REG_BOTTOM_Y;
    cfg_data <= CFG_DATA_BITS'(bottom);
    @(posedge clk);
    cfg_idx <= REG_SEG_COUNT;
    cfg_data <= CFG_DATA_BITS'(n);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_top = top;
    cur_bottom = bottom;
    cur_count = n;
  endtask

  function automatic int live_segments();
    return (cur_count > int'(MAX_SEGMENTS)) ? MAX_SEGMENTS : cur_count;
  endfunction

  function automatic int as_coord(int v);
    logic signed [COORD_BITS-1:0] c;
    c = COORD_BITS'(v);
    return c;
  endfunction

  task automatic load_segment(int s, int ux, int lx);
    if (s < int'(MAX_SEGMENTS)) begin
      lay_upper[s] = as_coord(ux);
      lay_lower[s] = as_coord(lx);
    end
    put_cmd(FUNC_LOAD, s, ux, lx, $urandom, $urandom);
  endtask

  // Sorted tables give each segment its own strip of the x range, so none cross.
  task automatic lay_table(int n, bit sorted);
    int width, base;
    width = COORD_SPAN / n;
    for (int i = 0; i < n; i++) begin
      base = COORD_MIN + i * width;
      if (sorted)
        load_segment(i, base + int'($urandom_range(0, width - 1)),
                     base + int'($urandom_range(0, width - 1)));
      else
        load_segment(i, $urandom, $urandom);
    end
  endtask

  // Mostly points inside the box, many exactly on or next to a segment end.
  task automatic place_point();
    int mode, s, nseg, px, py, ylo, yhi;
    nseg = live_segments();
    mode = $urandom_range(0, 9);
    px = as_coord($urandom);
    py = as_coord($urandom);
    ylo = (cur_top < cur_bottom) ? cur_top : cur_bottom;
    yhi = (cur_top < cur_bottom) ? cur_bottom : cur_top;
    if (mode < 4) begin
      py = ylo + int'($urandom_range(0, yhi - ylo));
    end else if (mode < 8 && nseg > 0) begin
      s = $urandom_range(0, nseg - 1);
      if ($urandom_range(0, 1)) begin
        px = lay_upper[s];
        py = cur_top;
      end else begin
        px = lay_lower[s];
        py = cur_bottom;
      end
      if (mode >= 6) px = px + int'($urandom_range(0, 2)) - 1;
    end
    put_cmd(FUNC_PLACE, $urandom, $urandom, $urandom, px, py);
  endtask

  task automatic read_counter();
    int s;
    s = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, live_segments());
    put_cmd(FUNC_READ, s, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    func <= FUNC_LOAD;
    slot <= '0;
    upper_x <= '0;
    lower_x <= '0;
    point_x <= '0;
    point_y <= '0;
    cfg_we <= 1'b0;
    cfg_idx <= REG_TOP_Y;
    cfg_data <= '0;
    burst_left = 0;
    cur_top = 0;
    cur_bottom = 0;
    cur_count = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    settle();

    put_cmd(FUNC_PLACE, $urandom, $urandom, $urandom, COORD_MIN, COORD_MAX);
    put_cmd(FUNC_PLACE, $urandom, $urandom, $urandom, COORD_MAX, COORD_MIN);
    put_cmd(FUNC_READ, 0, $urandom, $urandom, $urandom, $urandom);
    put_cmd(FUNC_READ, MAX_SEGMENTS, $urandom, $urandom, $urandom, $urandom);
    put_cmd(FUNC_READ, SLOT_TOP, $urandom, $urandom, $urandom, $urandom);
    put_cmd(FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
    put_cmd(FUNC_READ, 0, $urandom, $urandom, $urandom, $urandom);
    load_segment(MAX_SEGMENTS, COORD_MAX, COORD_MIN);
    load_segment(SLOT_TOP, COORD_MIN, COORD_MAX);
    load_segment(0, COORD_MIN, COORD_MIN);
    load_segment(1, COORD_MAX, COORD_MAX);
    settle();
    write_regs(COORD_MAX, COORD_MIN, 2);
    put_cmd(FUNC_PLACE, $urandom, $urandom, $urandom, COORD_MIN, COORD_MAX);
    put_cmd(FUNC_PLACE, $urandom, $urandom, $urandom, COORD_MAX, COORD_MIN);
    put_cmd(FUNC_PLACE, $urandom, $urandom, $urandom, COORD_MAX, 0);
    put_cmd(FUNC_PLACE, $urandom, $urandom, $urandom, 0, 0);
    put_cmd(FUNC_PLACE, $urandom, $urandom, $urandom, COORD_MIN, COORD_MIN);
    put_cmd(FUNC_READ, 1, $urandom, $urandom, $urandom, $urandom);
    put_cmd(FUNC_READ, 2, $urandom, $urandom, $urandom, $urandom);
    put_cmd(FUNC_READ, MAX_SEGMENTS + 1, $urandom, $urandom, $urandom, $urandom);

    for (ph = 0; ph < PHASES; ph++) begin
      ty = as_coord($urandom);
      by = as_coord($urandom);
      if (ty < by) begin
        swap = ty;
        ty = by;
        by = swap;
      end
      case (ph)
        0: begin
          nsel = MAX_SEGMENTS;
          lay_table(nsel, 1'b1);
          ty = COORD_MAX;
          by = COORD_MIN;
        end
        1: begin
          nsel = SLOT_TOP;
          ty = COORD_MIN;
          by = COORD_MAX;
        end
        2: begin
          nsel = $urandom_range(1, 8);
          lay_table(nsel, 1'b1);
          by = ty;
        end
        3: nsel = 0;
        4: begin
          nsel = $urandom_range(2, 16);
          lay_table(nsel, 1'b0);
        end
        default: begin
          nsel = $urandom_range(1, 40);
          lay_table(nsel, 1'b1);
        end
      endcase
      settle();
      write_regs(ty, by, nsel);
      done = 0;
      while (done < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) place_point();
        else if (pick < 82) read_counter();
        else if (pick < 84) put_cmd(FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
        else if (pick < 94) load_segment($urandom_range(0, MAX_SEGMENTS - 1), $urandom, $urandom);
        else load_segment($urandom_range(MAX_SEGMENTS, SLOT_TOP), $urandom, $urandom);
        if (pick < 94) done++;
      end
    end

    settle();
    if (fail_count == 0)
      $display("slab_point_location_histogram verification clean");
    else
      $display("slab_point_location_histogram verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/slph_pkg.sv
hw/rtl/slph_ctrl.sv
hw/rtl/slph_datapath.sv
hw/rtl/slab_point_location_histogram.sv
sim/slph_scoreboard.sv
sim/tb.sv
